// ===== hw/rtl/greedy_change_maker_macros.svh =====
// assertion macros used by the greedy change maker rtl
`ifndef GREEDY_CHANGE_MAKER_MACROS_SVH
`define GREEDY_CHANGE_MAKER_MACROS_SVH

// same-cycle implication, checked on i_clk outside reset
`define GCM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on i_clk outside reset
`define GCM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/gcm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_pkg
// Widths, register indexes and the sequencer program of the change maker.
// ----------------------------------------------------------------------------
package gcm_pkg;

    localparam int MAX_DENOMS = 6;
    localparam int DENOM_W    = 24;
    localparam int AMT_W      = 31;
    localparam int SLOT_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int BIT_CNT_W  = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IN_USE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DENOM0 = 3'd1;

    // program steps
    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_SORT     = 3'd1,
        ST_DIV_INIT = 3'd2,
        ST_DIV_STEP = 3'd3,
        ST_WAIT_OUT = 3'd4,
        ST_EMIT     = 3'd5,
        ST_DONE     = 3'd6
    } t_step;

    // jump conditions
    typedef enum logic [2:0] {
        C_NONE,
        C_NO_IN,
        C_PASS_LEFT,
        C_BIT_LEFT,
        C_OUT_BUSY,
        C_MORE,
        C_ALWAYS
    } t_cond;

    // one control word
    typedef struct packed {
        logic  in_rdy;
        logic  sort;
        logic  div_init;
        logic  div_step;
        logic  emit;
        t_cond cond;
        t_step target;
    } t_uword;

    // program rom
    function automatic t_uword ucode(input t_step pc);
        t_uword w;
        w = '{in_rdy: 1'b0, sort: 1'b0, div_init: 1'b0, div_step: 1'b0,
              emit: 1'b0, cond: C_ALWAYS, target: ST_IDLE};
        case (pc)
            ST_IDLE: begin
                w.in_rdy = 1'b1;
                w.cond   = C_NO_IN;
                w.target = ST_IDLE;
            end
            ST_SORT: begin
                w.sort   = 1'b1;
                w.cond   = C_PASS_LEFT;
                w.target = ST_SORT;
            end
            ST_DIV_INIT: begin
                w.div_init = 1'b1;
                w.cond     = C_NONE;
            end
            ST_DIV_STEP: begin
                w.div_step = 1'b1;
                w.cond     = C_BIT_LEFT;
                w.target   = ST_DIV_STEP;
            end
            ST_WAIT_OUT: begin
                w.cond   = C_OUT_BUSY;
                w.target = ST_WAIT_OUT;
            end
            ST_EMIT: begin
                w.emit   = 1'b1;
                w.cond   = C_MORE;
                w.target = ST_DIV_INIT;
            end
            ST_DONE: begin
                w.cond   = C_ALWAYS;
                w.target = ST_IDLE;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/gcm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_in_if / gcm_out_if
// Valid/ready channels carrying amounts in and note results out.
// ----------------------------------------------------------------------------
interface gcm_in_if;
    import gcm_pkg::*;

    logic             valid;
    logic             ready;
    logic [AMT_W-1:0] amount;

    modport source (output valid, output amount, input ready);
    modport sink   (input valid, input amount, output ready);
endinterface

interface gcm_out_if;
    import gcm_pkg::*;

    logic               valid;
    logic               ready;
    logic [DENOM_W-1:0] denom_value;
    logic [AMT_W-1:0]   note_count;
    logic [AMT_W-1:0]   remaining;
    logic               last_of_run;

    modport source (output valid, output denom_value, output note_count,
                    output remaining, output last_of_run, input ready);
    modport sink   (input valid, input denom_value, input note_count,
                    input remaining, input last_of_run, output ready);
endinterface

// ===== hw/rtl/greedy_change_maker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_change_maker
// Splits an amount into notes by the greedy rule over up to six denominations.
// ----------------------------------------------------------------------------
// One amount is taken at a time and gives one result per denomination in use,
// largest value first (equal values keep slot order), the last one flagged.
// A small microcoded sequencer steps a plain datapath: a load step, odd-even
// compare-exchange passes to sort the slots, then per denomination a setup
// step, a shared bit-serial restoring divider, an output check that waits
// while the previous result is still held with ready low, and an emit step.
// Configuration is taken on any cycle.
module greedy_change_maker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gcm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [gcm_pkg::DENOM_W-1:0]   i_cfg_data,
    gcm_in_if.sink                        i_in,
    gcm_out_if.source                     o_out
);
    import gcm_pkg::*;

    `include "greedy_change_maker_macros.svh"

    // configuration
    logic [SLOT_W-1:0]  r_in_use;
    logic [DENOM_W-1:0] r_denom [MAX_DENOMS];

    // sequencer
    t_step  r_pc, n_pc;
    t_uword w;
    logic   jump;

    // datapath
    logic [DENOM_W-1:0]   r_order [MAX_DENOMS];
    logic [DENOM_W-1:0]   n_order [MAX_DENOMS];
    logic [SLOT_W-1:0]    r_pass;
    logic [SLOT_W-1:0]    r_left;
    logic [BIT_CNT_W-1:0] r_bit;
    logic [AMT_W-1:0]     r_rem;
    logic [AMT_W-1:0]     r_dq;
    logic [DENOM_W-1:0]   r_prem;
    logic [DENOM_W:0]     trial;
    logic [SLOT_W-1:0]    n_slots;
    logic                 in_xfer;
    logic                 out_busy;
    logic                 div_zero;

    // output register
    logic                 r_out_valid;
    logic [DENOM_W-1:0]   r_out_denom;
    logic [AMT_W-1:0]     r_out_cnt;
    logic [AMT_W-1:0]     r_out_rem;
    logic                 r_out_last;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= SLOT_W'(1);
            for (int k = 0; k < MAX_DENOMS; k++) r_denom[k] <= DENOM_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_IN_USE) r_in_use <= i_cfg_data[SLOT_W-1:0];
            for (int k = 0; k < MAX_DENOMS; k++) begin
                if (i_cfg_idx == REG_DENOM0 + CFG_IDX_W'(k)) r_denom[k] <= i_cfg_data;
            end
        end
    end

    // saturated slot count
    always_comb begin
        if (r_in_use == '0) begin
            n_slots = SLOT_W'(1);
        end else if (r_in_use > SLOT_W'(MAX_DENOMS)) begin
            n_slots = SLOT_W'(MAX_DENOMS);
        end else begin
            n_slots = r_in_use;
        end
    end

    // control word decode
    always_comb begin
        w        = ucode(r_pc);
        in_xfer  = i_in.valid && w.in_rdy;
        out_busy = r_out_valid && !o_out.ready;
    end

    // next step
    always_comb begin
        case (w.cond)
            C_NONE:      jump = 1'b0;
            C_NO_IN:     jump = !i_in.valid;
            C_PASS_LEFT: jump = (r_pass != '0);
            C_BIT_LEFT:  jump = (r_bit != '0);
            C_OUT_BUSY:  jump = out_busy;
            C_MORE:      jump = (r_left != SLOT_W'(1));
            C_ALWAYS:    jump = 1'b1;
            default:     jump = 1'b1;
        endcase
        n_pc = jump ? w.target : t_step'(r_pc + 3'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // slot array: load, odd-even compare-exchange, shift out
    always_comb begin
        for (int k = 0; k < MAX_DENOMS; k++) n_order[k] = r_order[k];
        if (in_xfer) begin
            for (int k = 0; k < MAX_DENOMS; k++) begin
                n_order[k] = (SLOT_W'(k) < n_slots) ? r_denom[k] : '0;
            end
        end else if (w.sort) begin
            for (int k = 0; k + 1 < MAX_DENOMS; k++) begin
                if ((k % 2) == int'(r_pass[0]) && r_order[k+1] > r_order[k]) begin
                    n_order[k]   = r_order[k+1];
                    n_order[k+1] = r_order[k];
                end
            end
        end else if (w.emit) begin
            for (int k = 0; k + 1 < MAX_DENOMS; k++) n_order[k] = r_order[k+1];
            n_order[MAX_DENOMS-1] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_DENOMS; k++) r_order[k] <= n_order[k];
    end

    // counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass <= '0;
            r_left <= '0;
            r_bit  <= '0;
        end else begin
            if (in_xfer) begin
                r_pass <= SLOT_W'(MAX_DENOMS - 1);
                r_left <= n_slots;
            end else if (w.sort && r_pass != '0) begin
                r_pass <= r_pass - SLOT_W'(1);
            end else if (w.emit) begin
                r_left <= r_left - SLOT_W'(1);
            end
            if (w.div_init) begin
                r_bit <= BIT_CNT_W'(AMT_W - 1);
            end else if (w.div_step && r_bit != '0) begin
                r_bit <= r_bit - BIT_CNT_W'(1);
            end
        end
    end

    // restoring divider, one quotient bit a cycle
    assign trial    = {r_prem, r_dq[AMT_W-1]} - {1'b0, r_order[0]};
    assign div_zero = (r_order[0] == '0);

    always_ff @(posedge i_clk) begin
        if (in_xfer) r_rem <= i_in.amount;
        if (w.div_init) begin
            r_dq   <= r_rem;
            r_prem <= '0;
        end else if (w.div_step) begin
            if (!trial[DENOM_W]) begin
                r_prem <= trial[DENOM_W-1:0];
                r_dq   <= {r_dq[AMT_W-2:0], 1'b1};
            end else begin
                r_prem <= {r_prem[DENOM_W-2:0], r_dq[AMT_W-1]};
                r_dq   <= {r_dq[AMT_W-2:0], 1'b0};
            end
        end else if (w.emit && !div_zero) begin
            r_rem <= AMT_W'(r_prem);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w.emit) begin
            r_out_denom <= r_order[0];
            r_out_cnt   <= div_zero ? '0 : r_dq;
            r_out_rem   <= div_zero ? r_rem : AMT_W'(r_prem);
            r_out_last  <= (r_left == SLOT_W'(1));
        end
    end

    assign i_in.ready        = w.in_rdy;
    assign o_out.valid       = r_out_valid;
    assign o_out.denom_value = r_out_denom;
    assign o_out.note_count  = r_out_cnt;
    assign o_out.remaining   = r_out_rem;
    assign o_out.last_of_run = r_out_last;

    // checks
    `GCM_ASSERT_NEXT(a_accept_sorts, in_xfer, r_pc == ST_SORT, "accepted amount did not start sort")
    `GCM_ASSERT_NEXT(a_div_ends, (r_pc == ST_DIV_STEP) && (r_bit == '0), r_pc == ST_WAIT_OUT, "divider overran")
    `GCM_ASSERT_NOW(a_rem_bound, w.emit && !div_zero, r_prem < r_order[0], "remainder not below divisor")
    `GCM_ASSERT_NOW(a_emit_free, w.emit, !r_out_valid, "emit onto occupied output register")
    `GCM_ASSERT_NOW(a_rose_emit, $rose(r_out_valid), $past(r_pc) == ST_EMIT, "result shown without emit")

endmodule

// ===== tb/greedy_change_maker_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_change_maker_checker
// Watches the change maker channels and checks every note result.
// ----------------------------------------------------------------------------
// Keeps its own copy of the denomination registers by snooping the write port.
// Each amount transfer is split by the greedy rule into the expected notes.
// Each result transfer is compared field by field with the oldest expected note.
// ----------------------------------------------------------------------------
module greedy_change_maker_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gcm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [gcm_pkg::DENOM_W-1:0]   i_cfg_data,
    gcm_in_if                             i_amt,
    gcm_out_if                            i_note,
    output int                            o_mismatches,
    output int                            o_pending,
    output int                            o_notes_seen
);
    import gcm_pkg::*;

    typedef struct packed {
        logic [DENOM_W-1:0] denom;
        logic [AMT_W-1:0]   count;
        logic [AMT_W-1:0]   remaining;
        logic               last;
    } t_payout_note;

    // snooped configuration
    logic [SLOT_W-1:0]  slots_cfg;
    logic [DENOM_W-1:0] denom_cfg [MAX_DENOMS];

    t_payout_note expected_notes [$];
    int           mismatch_count  = 0;
    int           notes_seen      = 0;

    // greedy split of one amount into the notes it must produce
    function automatic void predict_payout(input logic [AMT_W-1:0] amount);
        logic [DENOM_W-1:0] sorted [MAX_DENOMS];
        logic [DENOM_W-1:0] swap;
        logic [AMT_W-1:0]   left;
        logic [AMT_W-1:0]   notes;
        int                 used;
        t_payout_note       entry;
        if (slots_cfg == 0)
            used = 1;
        else if (slots_cfg > MAX_DENOMS)
            used = MAX_DENOMS;
        else
            used = int'(slots_cfg);
        for (int k = 0; k < MAX_DENOMS; k++) sorted[k] = denom_cfg[k];
        // descending, equal values keep slot order
        for (int a = 0; a < used - 1; a++) begin
            for (int b = used - 1; b > a; b--) begin
                if (sorted[b] > sorted[b-1]) begin
                    swap        = sorted[b];
                    sorted[b]   = sorted[b-1];
                    sorted[b-1] = swap;
                end
            end
        end
        left = amount;
        for (int k = 0; k < used; k++) begin
            notes = '0;
            // a zero denomination pays nothing and leaves the amount alone
            if (sorted[k] != 0) begin
                notes = left / {7'd0, sorted[k]};
                left  = left - notes * {7'd0, sorted[k]};
            end
            entry.denom     = sorted[k];
            entry.count     = notes;
            entry.remaining = left;
            entry.last      = (k == used - 1);
            expected_notes.push_back(entry);
        end
    endfunction

    function automatic void compare_field(input string name, input longint unsigned want,
                                          input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_payout_note want;
        if (!i_rst_n) begin
            slots_cfg = 3'd1;
            foreach (denom_cfg[k]) denom_cfg[k] = 24'd1;
        end else begin
            // register writes, unmapped indexes dropped
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_IN_USE)
                    slots_cfg = i_cfg_data[SLOT_W-1:0];
                else if (i_cfg_idx >= REG_DENOM0 && i_cfg_idx < REG_DENOM0 + MAX_DENOMS)
                    denom_cfg[i_cfg_idx - REG_DENOM0] = i_cfg_data;
            end
            // result transfer against the oldest expected note
            if (i_note.valid && i_note.ready) begin
                notes_seen++;
                if (expected_notes.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %0d/%0d/%0d/%0d",
                             $time, i_note.denom_value, i_note.note_count,
                             i_note.remaining, i_note.last_of_run);
                    mismatch_count++;
                end else begin
                    want = expected_notes.pop_front();
                    compare_field("denom_value", 64'(want.denom), 64'(i_note.denom_value));
                    compare_field("note_count", 64'(want.count), 64'(i_note.note_count));
                    compare_field("remaining", 64'(want.remaining), 64'(i_note.remaining));
                    compare_field("last_of_run", 64'(want.last), 64'(i_note.last_of_run));
                end
            end
            // amount transfer
            if (i_amt.valid && i_amt.ready) predict_payout(i_amt.amount);
        end
        o_mismatches <= mismatch_count;
        o_pending    <= expected_notes.size();
        o_notes_seen <= notes_seen;
    end

endmodule

// ===== tb/greedy_change_maker_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_change_maker_test
// Directed and random regression of the greedy change maker.
// ----------------------------------------------------------------------------
// Walks the block through a series of denomination setups: reset values, a
// six-slot set with a tie, a zero and the extreme values, clamped slot counts,
// and random setups mixing face values, full-range values and repeats. Each
// setup gets a batch of amounts while both channels idle in random bursts.
// The checker beside the block predicts and compares every note result.
// ----------------------------------------------------------------------------
module greedy_change_maker_test;
    import gcm_pkg::*;

    localparam int ITEM_TARGET   = 470;
    localparam int QUIET_AFTER   = 390;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [DENOM_W-1:0]   cfg_data;

    gcm_in_if  amt_ch ();
    gcm_out_if note_ch ();

    int mismatches;
    int pending;
    int notes_seen;

    // stimulus state
    bit                 idle_on     = 1'b0;
    int                 items_sent  = 0;
    int                 setups      = 0;
    int                 stall_left  = 0;
    int                 idle_cycles = 0;
    logic [DENOM_W-1:0] cfg_denom [MAX_DENOMS];

    greedy_change_maker u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (amt_ch),
        .o_out      (note_ch)
    );

    greedy_change_maker_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_amt        (amt_ch),
        .i_note       (note_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_notes_seen (notes_seen)
    );

    always #10 clk = ~clk;

    // result side back-pressure in bursts
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            note_ch.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = int'($urandom_range(1, 13)) - 1;
            note_ch.ready <= 1'b0;
        end else begin
            note_ch.ready <= 1'b1;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if (!rst_n || (amt_ch.valid && amt_ch.ready) || (note_ch.valid && note_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("%0t: watchdog, no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // one register write, taken at the next edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DENOM_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        if (idx >= REG_DENOM0 && idx < REG_DENOM0 + MAX_DENOMS) cfg_denom[idx - REG_DENOM0] = data;
        @(posedge clk);
    endtask

    // one amount transfer, with an optional gap in front
    task automatic send_amount(input logic [AMT_W-1:0] amount);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            amt_ch.valid  <= 1'b0;
            amt_ch.amount <= AMT_W'($urandom);
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        amt_ch.valid  <= 1'b1;
        amt_ch.amount <= amount;
        @(posedge clk);
        while (!amt_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    // hold the sender until every expected note is back
    task automatic drain_notes();
        amt_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // random slot count and denominations
    task automatic random_setup();
        logic [SLOT_W-1:0]  slots;
        logic [DENOM_W-1:0] value;
        int                 pick;
        int                 scale;
        if ($urandom_range(0, 9) == 0)
            slots = ($urandom_range(0, 1) == 0) ? 3'd0 : 3'd7;
        else
            slots = 3'($urandom_range(1, MAX_DENOMS));
        write_reg(REG_IN_USE, (DENOM_W'($urandom) & 24'hFFFFF8) | {21'd0, slots});
        for (int k = 0; k < MAX_DENOMS; k++) begin
            if ($urandom_range(0, 4) != 0) begin
                pick = $urandom_range(0, 19);
                if (pick < 8) begin
                    // face values 1, 2, 5 .. 5000
                    pick  = $urandom_range(0, 11);
                    scale = 1;
                    repeat (pick / 3) scale *= 10;
                    value = DENOM_W'(scale * ((pick % 3 == 0) ? 1 : (pick % 3 == 1) ? 2 : 5));
                end else if (pick < 12) begin
                    value = DENOM_W'($urandom_range(1, 5000));
                end else if (pick < 16) begin
                    value = DENOM_W'($urandom);
                end else if (pick < 18) begin
                    value = (k > 0) ? cfg_denom[k-1] : 24'hFFFFFF;
                end else if (pick == 18) begin
                    value = 24'hFFFFFF;
                end else begin
                    value = 24'd0;
                end
                write_reg(REG_DENOM0 + 3'(k), value);
            end
        end
        if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, DENOM_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    // amounts shaped around the current denominations
    function automatic logic [AMT_W-1:0] random_amount();
        logic [63:0] wide;
        int          slot;
        case ($urandom_range(0, 5))
            0, 1: wide = 64'($urandom);
            2: wide = 64'($urandom_range(0, 100000));
            3, 4: begin
                slot = $urandom_range(0, MAX_DENOMS - 1);
                wide = 64'(cfg_denom[slot]) * 64'($urandom_range(0, 40))
                     + 64'($urandom_range(0, 2)) - 64'd1;
            end
            default: wide = ($urandom_range(0, 1) == 0) ? 64'd0 : 64'h7FFF_FFFF;
        endcase
        return wide[AMT_W-1:0];
    endfunction

    initial begin
        int batch;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_data      = '0;
        amt_ch.valid  = 1'b0;
        amt_ch.amount = '0;
        foreach (cfg_denom[k]) cfg_denom[k] = 24'd1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset setup: one slot of value one
        idle_on = 1'b1;
        send_amount(31'd0);
        send_amount(31'h7FFF_FFFF);
        drain_notes();
        setups++;

        // six slots with a tie, a zero and both extremes
        write_reg(REG_IN_USE, 24'hFFFFFE);
        write_reg(REG_DENOM0 + 3'd0, 24'd500);
        write_reg(REG_DENOM0 + 3'd1, 24'hFFFFFF);
        write_reg(REG_DENOM0 + 3'd2, 24'd0);
        write_reg(REG_DENOM0 + 3'd3, 24'd500);
        write_reg(REG_DENOM0 + 3'd4, 24'd1);
        write_reg(REG_DENOM0 + 3'd5, 24'h800000);
        cfg_we <= 1'b0;
        send_amount(31'd0);
        send_amount(31'h7FFF_FFFF);
        send_amount(31'd1);
        send_amount(31'd499);
        send_amount(31'd500);
        drain_notes();
        send_amount(31'd1000);
        send_amount(31'h00FF_FFFF);
        send_amount(31'h0100_01F3);
        send_amount(31'h5555_5555);
        send_amount(31'h2AAA_AAAA);
        drain_notes();
        setups++;

        // slot count zero acts as one, a write past the list changes nothing
        write_reg(REG_IN_USE, 24'h000008);
        write_reg(REG_DENOM0, 24'hFFFFFF);
        write_reg(REG_UNUSED, 24'h00000C);
        cfg_we <= 1'b0;
        send_amount(31'h7FFF_FFFF);
        send_amount(31'h00FF_FFFE);
        send_amount(31'd3);
        drain_notes();
        setups++;

        // slot count seven saturates to six, all values equal
        write_reg(REG_IN_USE, 24'h000007);
        for (int k = 0; k < MAX_DENOMS; k++) write_reg(REG_DENOM0 + 3'(k), 24'd7);
        cfg_we <= 1'b0;
        send_amount(31'd48);
        send_amount(31'd6);
        send_amount(31'h7FFF_FFFF);
        drain_notes();
        setups++;

        // random setups, each with a batch of amounts
        while (items_sent < ITEM_TARGET) begin
            idle_on = (items_sent < QUIET_AFTER) && ($urandom_range(0, 3) != 0);
            random_setup();
            batch = $urandom_range(12, 30);
            for (int k = 0; k < batch && items_sent < ITEM_TARGET; k++) begin
                send_amount(random_amount());
                if (idle_on && $urandom_range(0, 19) == 0) drain_notes();
            end
            drain_notes();
            setups++;
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d amounts and %0d note results over %0d denomination setups",
                 items_sent, notes_seen, setups);
        $display("setups spanned one to six slots, clamped slot counts, zero and repeated values");
        if (mismatches == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
